// ===== sv/sprite_pixel_renderer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite renderer assertion macros
// Clocked property wrappers shared by the sprite renderer RTL.
// ----------------------------------------------------------------------------
`ifndef SPRITE_PIXEL_RENDERER_CORE_ASSERT_SVH
`define SPRITE_PIXEL_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite renderer assertion failed");

// Next-cycle implication, checked outside reset.
`define SPR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite renderer assertion failed");

`endif

// ===== sv/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite renderer package
// Geometry constants, derived widths and command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spr_pkg;

	localparam int SPR_W        = 8;
	localparam int SPR_H        = 8;
	localparam int NUM_BITMAPS  = 256;
	localparam int NUM_PALETTES = 64;
	localparam int PAL_ENTRIES  = 16;

	localparam int PIX_PER_SPR = SPR_W * SPR_H;
	localparam int BMP_DEPTH   = NUM_BITMAPS * PIX_PER_SPR;
	localparam int PAL_DEPTH   = NUM_PALETTES * PAL_ENTRIES;
	localparam int BMP_AW      = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;
	localparam int PAL_AW      = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
	localparam int COL_W       = (SPR_W > 1) ? $clog2(SPR_W) : 1;
	localparam int ROW_W       = (SPR_H > 1) ? $clog2(SPR_H) : 1;

	localparam int PIX_W   = 4;
	localparam int COLOR_W = 32;
	localparam int COORD_W = 9;

	typedef enum logic [1:0] {
		FUNC_LOAD_BMP = 2'd0,
		FUNC_LOAD_PAL = 2'd1,
		FUNC_DRAW     = 2'd2
	} func_t;

	// Per-pixel sideband that travels with the two memory reads.
	typedef struct packed {
		logic [COORD_W-1:0] pix_x;
		logic [COORD_W-1:0] pix_y;
		logic               last;
	} pix_meta_t;

endpackage

// ===== sv/spr_ram.sv =====
// ----------------------------------------------------------------------------
// Sprite renderer RAM
// Single write port, single read port, read data registered under enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// Read data holds while the reader is stalled.
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sprite_pixel_renderer_core.sv =====
// ----------------------------------------------------------------------------
// Sprite pixel renderer core
// Sprite blitter with bitmap store, palette store, flip and alpha test.
// ----------------------------------------------------------------------------
// A load transaction (bitmap pixel or palette entry) is taken and produces
// nothing on the output. An enabled draw transaction walks the SPR_W x SPR_H
// sprite pixels in row-major order, one pixel per cycle while the output does
// not stall, and occupies the block from its own acceptance to that of the
// next input transaction: the draw is taken, one bitmap read per pixel issues
// through the single read port of the bitmap RAM, and then the last pixel's
// palette read issues, since the input stays closed until no read of the draw
// is outstanding. Any stall on the output side holds the walk. A disabled or
// out-of-range draw is taken with no output. Both stores come up undefined
// after reset and must be written before they are drawn from.
`timescale 1ns / 1ps

`include "sprite_pixel_renderer_core_assert.svh"

module sprite_pixel_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata, low bit up: tile_index[7:0], palette_index[13:8], bmp_slot[19:14],
	// color_index[23:20], rgba[55:24], pos_x[63:56], pos_y[71:64], flags[74:72],
	// zero padding[79:75].
	input  logic [79:0] s_tdata,
	// tuser, low bit up: func[1:0].
	input  logic [1:0]  s_tuser,
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata, low bit up: pix_x[8:0], pix_y[17:9], color[49:18], zero padding[55:50].
	output logic [55:0] m_tdata,
	// tuser, low bit up: write[0].
	output logic [0:0]  m_tuser,
	output logic        m_tlast
);

	// Input field unpacking.
	logic [7:0]  in_tile;
	logic [5:0]  in_pal;
	logic [5:0]  in_offs;
	logic [3:0]  in_cidx;
	logic [31:0] in_rgba;
	logic [7:0]  in_pos_x;
	logic [7:0]  in_pos_y;
	logic [2:0]  in_flags;

	assign in_tile  = s_tdata[7:0];
	assign in_pal   = s_tdata[13:8];
	assign in_offs  = s_tdata[19:14];
	assign in_cidx  = s_tdata[23:20];
	assign in_rgba  = s_tdata[55:24];
	assign in_pos_x = s_tdata[63:56];
	assign in_pos_y = s_tdata[71:64];
	assign in_flags = s_tdata[74:72];

	logic s_accept;
	assign s_accept = s_tvalid && s_tready;

	// Draw context latched when an enabled draw is accepted.
	logic                   busy_q;
	logic [7:0]             tile_q;
	logic [5:0]             pal_q;
	logic [7:0]             pos_x_q;
	logic [7:0]             pos_y_q;
	logic                   hflip_q;
	logic                   vflip_q;
	logic [spr_pkg::COL_W-1:0] col_q;
	logic [spr_pkg::ROW_W-1:0] row_q;

	// Pipeline: stage 1 waits on bitmap read data, stage 2 on palette data.
	logic                   valid_s1;
	spr_pkg::pix_meta_t     meta_s1;
	logic                   valid_s2;
	spr_pkg::pix_meta_t     meta_s2;
	logic                   inrange_s2;

	// Output register.
	logic                   m_valid_q;
	spr_pkg::pix_meta_t     m_meta_q;
	logic [31:0]            m_color_q;
	logic                   m_write_q;

	// The whole pipeline moves together whenever the output register can load.
	logic advance;
	assign advance = !m_valid_q || m_tready;

	// A new transaction waits until every read of the current draw has issued,
	// so a load can never overtake a pending read of the same entry.
	assign s_tready = !busy_q && !valid_s1;

	// Command decode and store writes.
	logic draw_ok;
	logic bmp_we;
	logic pal_we;
	logic [spr_pkg::BMP_AW-1:0] bmp_waddr;
	logic [spr_pkg::PAL_AW-1:0] pal_waddr;

	always_comb begin
		draw_ok = 1'b0;
		bmp_we  = 1'b0;
		pal_we  = 1'b0;
		case (s_tuser)
			spr_pkg::FUNC_LOAD_BMP: begin
				bmp_we = s_accept && (32'(in_tile) < 32'(spr_pkg::NUM_BITMAPS))
					&& (32'(in_offs) < 32'(spr_pkg::PIX_PER_SPR));
			end
			spr_pkg::FUNC_LOAD_PAL: begin
				pal_we = s_accept && (32'(in_pal) < 32'(spr_pkg::NUM_PALETTES))
					&& (32'(in_cidx) < 32'(spr_pkg::PAL_ENTRIES));
			end
			spr_pkg::FUNC_DRAW: begin
				draw_ok = s_accept && in_flags[0]
					&& (32'(in_tile) < 32'(spr_pkg::NUM_BITMAPS))
					&& (32'(in_pal) < 32'(spr_pkg::NUM_PALETTES));
			end
			default: begin
				draw_ok = 1'b0;
			end
		endcase
	end

	assign bmp_waddr = spr_pkg::BMP_AW'(in_tile) * spr_pkg::BMP_AW'(spr_pkg::PIX_PER_SPR)
		+ spr_pkg::BMP_AW'(in_offs);
	assign pal_waddr = spr_pkg::PAL_AW'(in_pal) * spr_pkg::PAL_AW'(spr_pkg::PAL_ENTRIES)
		+ spr_pkg::PAL_AW'(in_cidx);

	// Pixel walk: screen position comes from the counters, the source position
	// is the mirrored one under the flip flags.
	logic [spr_pkg::COL_W-1:0]  src_col;
	logic [spr_pkg::ROW_W-1:0]  src_row;
	logic                       col_end;
	logic                       row_end;
	logic                       issue;
	logic [spr_pkg::BMP_AW-1:0] bmp_raddr;
	spr_pkg::pix_meta_t         meta_s0;

	assign col_end = (col_q == spr_pkg::COL_W'(spr_pkg::SPR_W - 1));
	assign row_end = (row_q == spr_pkg::ROW_W'(spr_pkg::SPR_H - 1));
	assign src_col = hflip_q ? (spr_pkg::COL_W'(spr_pkg::SPR_W - 1) - col_q) : col_q;
	assign src_row = vflip_q ? (spr_pkg::ROW_W'(spr_pkg::SPR_H - 1) - row_q) : row_q;
	assign issue   = busy_q && advance;

	assign bmp_raddr = spr_pkg::BMP_AW'(tile_q) * spr_pkg::BMP_AW'(spr_pkg::PIX_PER_SPR)
		+ spr_pkg::BMP_AW'(src_row) * spr_pkg::BMP_AW'(spr_pkg::SPR_W)
		+ spr_pkg::BMP_AW'(src_col);

	assign meta_s0.pix_x = spr_pkg::COORD_W'(pos_x_q) + spr_pkg::COORD_W'(col_q);
	assign meta_s0.pix_y = spr_pkg::COORD_W'(pos_y_q) + spr_pkg::COORD_W'(row_q);
	assign meta_s0.last  = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (draw_ok) begin
			busy_q <= 1'b1;
			col_q  <= '0;
			row_q  <= '0;
		end else if (issue) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					busy_q <= 1'b0;
					row_q  <= '0;
				end else begin
					row_q <= row_q + spr_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + spr_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_ok) begin
			tile_q  <= in_tile;
			pal_q   <= in_pal;
			pos_x_q <= in_pos_x;
			pos_y_q <= in_pos_y;
			hflip_q <= in_flags[1];
			vflip_q <= in_flags[2];
		end
	end

	// Bitmap store.
	logic [spr_pkg::PIX_W-1:0] bmp_rdata;

	spr_ram #(
		.WIDTH (spr_pkg::PIX_W),
		.DEPTH (spr_pkg::BMP_DEPTH)
	) u_bmp_ram (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bmp_waddr),
		.wdata (in_cidx),
		.re    (issue),
		.raddr (bmp_raddr),
		.rdata (bmp_rdata)
	);

	// Palette lookup from the bitmap value. A value beyond the palette size
	// gives a transparent black pixel; the palette read still issues.
	logic                       pal_hit;
	logic                       pal_re;
	logic [spr_pkg::PAL_AW-1:0] pal_raddr;
	logic [spr_pkg::COLOR_W-1:0] pal_rdata;

	assign pal_hit   = (32'(bmp_rdata) < 32'(spr_pkg::PAL_ENTRIES));
	assign pal_re    = valid_s1 && advance;
	assign pal_raddr = spr_pkg::PAL_AW'(pal_q) * spr_pkg::PAL_AW'(spr_pkg::PAL_ENTRIES)
		+ spr_pkg::PAL_AW'(bmp_rdata);

	spr_ram #(
		.WIDTH (spr_pkg::COLOR_W),
		.DEPTH (spr_pkg::PAL_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (in_rgba),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// Stage valids and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1  <= busy_q;
			valid_s2  <= valid_s1;
			m_valid_q <= valid_s2;
		end
	end

	logic [spr_pkg::COLOR_W-1:0] color_s2;
	assign color_s2 = inrange_s2 ? pal_rdata : '0;

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1    <= meta_s0;
			meta_s2    <= meta_s1;
			inrange_s2 <= pal_hit;
			m_meta_q   <= meta_s2;
			m_color_q  <= color_s2;
			m_write_q  <= inrange_s2 && (color_s2[7:0] != 8'h00);
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {6'd0, m_color_q, m_meta_q.pix_y, m_meta_q.pix_x};
	assign m_tuser[0] = m_write_q;
	assign m_tlast    = m_meta_q.last;

	// No transaction is taken while a draw is still issuing reads.
	`SPR_ASSERT_IMPL(a_no_accept_while_busy, busy_q || valid_s1, !s_tready)
	// A stalled pipeline keeps its pixel in the bitmap read stage.
	`SPR_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance, valid_s1)
	// A pixel that waits on the output keeps its content.
	`SPR_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// An accepted enabled draw starts the walk.
	`SPR_ASSERT_NEXT(a_draw_starts, draw_ok, busy_q)

endmodule
